### hw/rtl/mcct_pkg.sv
// mcct_pkg: constants, types and lookup tables shared by the marching cubes cell triangulator.
// No dependencies.
package mcct_pkg;

	localparam int GRID_DIM    = 256;
	localparam int FRAC_BITS   = 8;
	localparam int SMP_W       = 16;
	localparam int MAG_W       = SMP_W + 1;
	localparam int POS_W       = 17;
	localparam int CELL_W      = 8;
	localparam int GCMP_W      = 13;
	localparam int BASE_W      = CELL_W + 1 + FRAC_BITS;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int ROW_W       = 64;
	localparam int NTRI_W      = 3;

	// step codes: direction of an edge along one axis
	localparam logic [1:0] STP_NONE  = 2'd0;
	localparam logic [1:0] STP_PLUS  = 2'd1;
	localparam logic [1:0] STP_MINUS = 2'd2;

	// corner offsets, bit k for corner k
	localparam logic [7:0] CORNER_DX = 8'b01100110;
	localparam logic [7:0] CORNER_DY = 8'b11001100;
	localparam logic [7:0] CORNER_DZ = 8'b11110000;

	localparam logic [11:0][2:0] EDGE_A = {3'd3, 3'd2, 3'd1, 3'd0, 3'd7, 3'd6, 3'd5, 3'd4,
		3'd3, 3'd2, 3'd1, 3'd0};
	localparam logic [11:0][2:0] EDGE_B = {3'd7, 3'd6, 3'd5, 3'd4, 3'd4, 3'd7, 3'd6, 3'd5,
		3'd0, 3'd3, 3'd2, 3'd1};

	typedef struct packed {
		logic [CELL_W-1:0]           cx;
		logic [CELL_W-1:0]           cy;
		logic [CELL_W-1:0]           cz;
		logic [7:0][SMP_W-1:0]       val;
		logic [ROW_W-1:0]            row;
		logic [NTRI_W-1:0]           ntri;
	} cell_t;

	typedef struct packed {
		logic [2:0][POS_W-1:0] base;
		logic [2:0][1:0]       stp;
	} geo_t;

	typedef struct packed {
		logic signed [MAG_W-1:0] num;
		logic signed [MAG_W-1:0] den;
		geo_t                    geo;
	} dif_t;

	typedef struct packed {
		logic [MAG_W-1:0]     rem;
		logic [MAG_W-1:0]     dvs;
		logic [FRAC_BITS-1:0] quo;
		logic                 frc_zero;
		logic                 frc_one;
		geo_t                 geo;
	} div_t;

	// Triangle rows: edge digits in table order, topped by an f marker nibble.
	localparam logic [ROW_W-1:0] TRI_ROW [256] = '{
		64'hf, 64'hf083, 64'hf019, 64'hf183981,
		64'hf12a, 64'hf08312a, 64'hf92a029, 64'hf2832a8a98,
		64'hf3b2, 64'hf0b28b0, 64'hf19023b, 64'hf1b219b98b,
		64'hf3a1ba3, 64'hf0a108a8ba, 64'hf3903b9ba9, 64'hf98aa8b,
		64'hf478, 64'hf430734, 64'hf019847, 64'hf419471731,
		64'hf12a847, 64'hf34730412a, 64'hf92a902847, 64'hf2a9297273794,
		64'hf8473b2, 64'hfb47b24204, 64'hf90184723b, 64'hf47b94b9b2921,
		64'hf3a13ba784, 64'hf1ba14b1047b4, 64'hf47890b9bab03, 64'hf47b4b99ba,
		64'hf954, 64'hf954083, 64'hf054150, 64'hf854835315,
		64'hf12a954, 64'hf30812a495, 64'hf52a542402, 64'hf2a5325354348,
		64'hf95423b, 64'hf0b208b495, 64'hf05401523b, 64'hf21525828b485,
		64'hfa3ba13954, 64'hf4950818a18ba, 64'hf54050b5bab03, 64'hf54858aa8b,
		64'hf978579, 64'hf930953573, 64'hf078017157, 64'hf153357,
		64'hf978957a12, 64'hfa12950530573, 64'hf802825857a52, 64'hf2a5253357,
		64'hf7957893b2, 64'hf95797292027b, 64'hf23b018178157, 64'hfb21b17715,
		64'hf958857a13a3b, 64'hf5705097b010aba0, 64'hfba0b03a50807570, 64'hfba57b5,
		64'hfa65, 64'hf0835a6, 64'hf9015a6, 64'hf1831985a6,
		64'hf165261, 64'hf165126308, 64'hf965906026, 64'hf598582526328,
		64'hf23ba65, 64'hfb08b20a65, 64'hf01923b5a6, 64'hf5a61929b298b,
		64'hf63b653513, 64'hf08b0b50515b6, 64'hf3b6036065059, 64'hf65969bb98,
		64'hf5a6478, 64'hf43047365a, 64'hf1905a6847, 64'hfa65197173794,
		64'hf612651478, 64'hf125526304347, 64'hf847905065026, 64'hf739794329596269,
		64'hf3b2784a65, 64'hf5a647242027b, 64'hf01947823b5a6, 64'hf9219b294b7b45a6,
		64'hf8473b53515b6, 64'hf51b5b610b7b404b, 64'hf059065036b63847, 64'hf65969b4797b9,
		64'hfa4964a, 64'hf4a649a083, 64'hfa01a60640, 64'hf83181686461a,
		64'hf149124264, 64'hf308129249264, 64'hf024426, 64'hf832824426,
		64'hfa49a64b23, 64'hf08228b49a4a6, 64'hf3b201606461a, 64'hf64161a48121b8b1,
		64'hf964936913b63, 64'hf8b1810b61914641, 64'hf3b6360064, 64'hf648b68,
		64'hf7a678a89a, 64'hf0730a709a67a, 64'hfa671a7178180, 64'hfa67a71173,
		64'hf126168189867, 64'hf269291679093739, 64'hf780706602, 64'hf732672,
		64'hf23ba68a89867, 64'hf20727b09767a9a7, 64'hf1801781a767a23b, 64'hfb21b17a61671,
		64'hf896867916b63136, 64'hf091b67, 64'hf7807063b0b60, 64'hf7b6,
		64'hf76b, 64'hf308b76, 64'hf019b76, 64'hf819831b76,
		64'hfa1267b, 64'hf12a30867b, 64'hf2902a967b, 64'hf6b72a3a83a98,
		64'hf723627, 64'hf708760620, 64'hf276237019, 64'hf162186198876,
		64'hfa76a17137, 64'hfa7617a187108, 64'hf03707a0a96a7, 64'hf76a7a88a9,
		64'hf684b86, 64'hf36b306046, 64'hf86b846901, 64'hf946963931b36,
		64'hf6846b82a1, 64'hf12a30b06b046, 64'hf4b846b0292a9, 64'hfa93a32943b36463,
		64'hf823842462, 64'hf042462, 64'hf190234246438, 64'hf194142246,
		64'hf8138618466a1, 64'hfa10a06604, 64'hf4634386a3039a93, 64'hfa946a4,
		64'hf49576b, 64'hf083495b76, 64'hf50154076b, 64'hfb76834354315,
		64'hf954a1276b, 64'hf6b712a083495, 64'hf76b54a42a402, 64'hf348354325a52b76,
		64'hf723762549, 64'hf954086062687, 64'hf362376150540, 64'hf628687218485158,
		64'hf954a16176137, 64'hf16a176107870954, 64'hf40a4a503a6a737a, 64'hf76a7a854a48a,
		64'hf6956b9b89, 64'hf36b036056095, 64'hf0b805b01556b, 64'hf6b3635531,
		64'hf12a95b9b8b56, 64'hf0b306b09656912a, 64'hfb85b56805a52025, 64'hf6b36352a3a53,
		64'hf589528562382, 64'hf956960062, 64'hf158180568382628, 64'hf156216,
		64'hf13616a386569896, 64'hfa10a06950560, 64'hf03856a, 64'hfa56,
		64'hfb5a75b, 64'hfb5ab75830, 64'hf5b75ab190, 64'hfa75ab7981831,
		64'hfb12b17751, 64'hf08312717572b, 64'hf9759279022b7, 64'hf75272b592328982,
		64'hf25a235375, 64'hf820852875a25, 64'hf9015a35373a2, 64'hf982921872a25752,
		64'hf135375, 64'hf087071175, 64'hf903935537, 64'hf987597,
		64'hf5845a8ab8, 64'hf5045b05abb30, 64'hf01984a8aba45, 64'hfab4a45b34941314,
		64'hf2512852b8458, 64'hf04b0b345b2b151b, 64'hf0250592b5458b85, 64'hf9452b3,
		64'hf25a352345384, 64'hf5a2524420, 64'hf3a235a385458019, 64'hf5a2524192942,
		64'hf845853351, 64'hf045105, 64'hf845853905035, 64'hf945,
		64'hf4b749b9ab, 64'hf0834979b79ab, 64'hf1ab1b414074b, 64'hf3143481a474bab4,
		64'hf4b79b492b912, 64'hf9749b791b2b1083, 64'hfb74b42240, 64'hfb74b42834324,
		64'hf29a279237749, 64'hf9a7974a27870207, 64'hf37a3a274a1a040a, 64'hf1a2874,
		64'hf491417713, 64'hf491417081871, 64'hf403743, 64'hf487,
		64'hf9a8ab8, 64'hf30939bb9a, 64'hf01a0a88ab, 64'hf31ab3a,
		64'hf12b1b99b8, 64'hf30939b1292b9, 64'hf02b80b, 64'hf32b,
		64'hf23828aa89, 64'hf9a2092, 64'hf23828a0181a8, 64'hf1a2,
		64'hf138918, 64'hf091, 64'hf038, 64'hf
	};

	// triangle count: position of the marker nibble, three digits per triangle
	function automatic logic [NTRI_W-1:0] row_ntri(input logic [ROW_W-1:0] row);
		logic [NTRI_W-1:0] n;
		n = '0;
		for (int i = 1; i <= 5; i++) begin
			if (row[i*12 +: 4] == 4'hf) n = NTRI_W'(i);
		end
		return n;
	endfunction

endpackage

### hw/rtl/mcct_front.sv
// mcct_front: takes cell requests, forms the case index, looks up the triangle row.
// Depends on mcct_pkg.
module mcct_front import mcct_pkg::*; (
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [CELL_W-1:0]       cell_x,
	input  logic [CELL_W-1:0]       cell_y,
	input  logic [CELL_W-1:0]       cell_z,
	input  logic [7:0][SMP_W-1:0]   val,
	input  logic [SMP_W-1:0]        iso_level,
	input  logic                    q_full,
	output logic                    q_push,
	output cell_t                   q_data
);

	logic [7:0] case_idx;
	logic       in_grid;
	logic       accept;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			case_idx[i] = $signed(val[i]) < $signed(iso_level);
		end
	end

	assign in_grid = ((GCMP_W'(cell_x) + GCMP_W'(1)) < GCMP_W'(GRID_DIM)) &&
		((GCMP_W'(cell_y) + GCMP_W'(1)) < GCMP_W'(GRID_DIM)) &&
		((GCMP_W'(cell_z) + GCMP_W'(1)) < GCMP_W'(GRID_DIM));

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	assign q_data.cx   = cell_x;
	assign q_data.cy   = cell_y;
	assign q_data.cz   = cell_z;
	assign q_data.val  = val;
	assign q_data.row  = TRI_ROW[case_idx];
	assign q_data.ntri = row_ntri(q_data.row);

	// cells with nothing to emit, or outside the grid, are dropped here
	assign q_push = accept && in_grid && (q_data.ntri != '0);

endmodule

### hw/rtl/mcct_queue.sv
// mcct_queue: short FIFO of classified cells between front and back.
// Depends on mcct_pkg.
module mcct_queue import mcct_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  cell_t wdata,
	output logic  full,
	input  logic  pop,
	output logic  head_valid,
	output cell_t head
);

	cell_t             mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop) cnt_q <= cnt_q + QCNT_W'(1);
			else if (pop && !push) cnt_q <= cnt_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wdata;
	end

endmodule

### hw/rtl/mcct_back.sv
// mcct_back: steps through the triangles of each queued cell, interpolates edge crossings
// through a pipelined restoring divider. Depends on mcct_pkg.
module mcct_back import mcct_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [SMP_W-1:0]              iso_level,
	input  logic                          head_valid,
	input  cell_t                         head,
	output logic                          head_pop,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0][2:0][POS_W-1:0]    vtx,
	output logic                          last_triangle
);

	logic [NTRI_W-1:0] tri_q;
	logic              en;
	logic              issue;
	logic              is_last;

	dif_t dif_d [3];
	dif_t dif_s1 [3];
	logic valid_s1;
	logic last_s1;

	div_t div_s [FRAC_BITS+1][3];
	logic div_vld_s [FRAC_BITS+1];
	logic div_last_s [FRAC_BITS+1];

	logic                      out_valid_q;
	logic                      last_q;
	logic [2:0][2:0][POS_W-1:0] vtx_q;

	function automatic div_t div_load(input dif_t d);
		div_t             o;
		logic [MAG_W-1:0] an;
		logic [MAG_W-1:0] ad;
		an = d.num[MAG_W-1] ? MAG_W'(-d.num) : MAG_W'(d.num);
		ad = d.den[MAG_W-1] ? MAG_W'(-d.den) : MAG_W'(d.den);
		o.rem      = an;
		o.dvs      = ad;
		o.quo      = '0;
		// fraction is zero on equal samples, zero numerator or opposite signs
		o.frc_zero = (d.den == '0) || (d.num == '0) || (d.num[MAG_W-1] != d.den[MAG_W-1]);
		o.frc_one  = (an >= ad);
		o.geo      = d.geo;
		return o;
	endfunction

	function automatic div_t div_step(input div_t d);
		div_t           o;
		logic [MAG_W:0] r2;
		logic           qb;
		o  = d;
		r2 = {d.rem, 1'b0};
		qb = (r2 >= {1'b0, d.dvs});
		if (qb) r2 = r2 - {1'b0, d.dvs};
		o.rem = r2[MAG_W-1:0];
		o.quo = {d.quo[FRAC_BITS-2:0], qb};
		return o;
	endfunction

	assign en       = !out_valid_q || !out_stall;
	assign issue    = head_valid && en;
	assign is_last  = (tri_q == head.ntri - NTRI_W'(1));
	assign head_pop = issue && is_last;

	// edge lookup and differences for the three vertices of triangle tri_q
	always_comb begin
		logic [3:0]            nib;
		logic [3:0]            e;
		logic [2:0]            ca;
		logic [2:0]            cb;
		logic [2:0]            offa;
		logic [2:0]            offb;
		logic [2:0][CELL_W-1:0] cel;
		logic [CELL_W:0]       sum;
		cel = {head.cz, head.cy, head.cx};
		for (int v = 0; v < 3; v++) begin
			nib  = 4'(3 * int'(head.ntri) - 1 - (3 * int'(tri_q) + v));
			e    = head.row[{nib, 2'b00} +: 4];
			ca   = EDGE_A[e];
			cb   = EDGE_B[e];
			offa = {CORNER_DZ[ca], CORNER_DY[ca], CORNER_DX[ca]};
			offb = {CORNER_DZ[cb], CORNER_DY[cb], CORNER_DX[cb]};
			dif_d[v].num = $signed({iso_level[SMP_W-1], iso_level}) -
				$signed({head.val[ca][SMP_W-1], head.val[ca]});
			dif_d[v].den = $signed({head.val[cb][SMP_W-1], head.val[cb]}) -
				$signed({head.val[ca][SMP_W-1], head.val[ca]});
			for (int k = 0; k < 3; k++) begin
				sum = {1'b0, cel[k]} + (CELL_W+1)'(offa[k]);
				dif_d[v].geo.base[k] = POS_W'(BASE_W'(sum) << FRAC_BITS);
				if (offb[k] && !offa[k]) dif_d[v].geo.stp[k] = STP_PLUS;
				else if (!offb[k] && offa[k]) dif_d[v].geo.stp[k] = STP_MINUS;
				else dif_d[v].geo.stp[k] = STP_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tri_q       <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i <= FRAC_BITS; i++) div_vld_s[i] <= 1'b0;
		end else begin
			if (issue) tri_q <= is_last ? '0 : tri_q + NTRI_W'(1);
			if (en) begin
				valid_s1     <= issue;
				div_vld_s[0] <= valid_s1;
				for (int i = 1; i <= FRAC_BITS; i++) div_vld_s[i] <= div_vld_s[i-1];
				out_valid_q  <= div_vld_s[FRAC_BITS];
			end
		end
	end

	always_ff @(posedge clk) begin
		logic [FRAC_BITS:0] mu;
		if (en) begin
			last_s1 <= is_last;
			div_last_s[0] <= last_s1;
			for (int i = 1; i <= FRAC_BITS; i++) div_last_s[i] <= div_last_s[i-1];
			last_q <= div_last_s[FRAC_BITS];
			for (int v = 0; v < 3; v++) begin
				dif_s1[v]   <= dif_d[v];
				div_s[0][v] <= div_load(dif_s1[v]);
				for (int i = 1; i <= FRAC_BITS; i++) div_s[i][v] <= div_step(div_s[i-1][v]);
				if (div_s[FRAC_BITS][v].frc_zero) mu = '0;
				else if (div_s[FRAC_BITS][v].frc_one) mu = {1'b1, {FRAC_BITS{1'b0}}};
				else mu = {1'b0, div_s[FRAC_BITS][v].quo};
				for (int k = 0; k < 3; k++) begin
					case (div_s[FRAC_BITS][v].geo.stp[k])
						STP_PLUS: vtx_q[v][k] <= div_s[FRAC_BITS][v].geo.base[k] + POS_W'(mu);
						STP_MINUS: vtx_q[v][k] <= div_s[FRAC_BITS][v].geo.base[k] - POS_W'(mu);
						default: vtx_q[v][k] <= div_s[FRAC_BITS][v].geo.base[k];
					endcase
				end
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign last_triangle = last_q;
	assign vtx           = vtx_q;

endmodule

### hw/rtl/marching_cubes_cell_triangulator.sv
// marching_cubes_cell_triangulator: top level, iso level register, front, queue, back.
// Depends on mcct_pkg, mcct_front, mcct_queue, mcct_back.
//
// Usage:
//   Input channel: one request per grid cell (coordinates plus eight corner samples),
//   accepted on a rising edge with in_valid high and in_stall low.
//   Output channel: one request per triangle (three vertices, fixed point with
//   FRAC_BITS fraction bits), last_triangle set on the final triangle of a cell,
//   handed over on an edge with out_valid high and out_stall low.
//   Config: cfg_we writes cfg_wdata into iso_level; write only while idle.
//   Throughput: the front takes one cell per cycle while in_stall is low; the back works
//   through a cell's triangles, one per cycle unless stalled, then pops the cell; cells with
//   none are dropped at the front. The back sets the sustained rate; a four-entry queue
//   between the two absorbs bursts. Pipeline: edge lookup, magnitude stage, one divider
//   stage per fraction bit, output register.
//   Reset: clears iso_level to 0 and empties queue and pipeline.
//   Receiver stall: while out_valid is high, the back pipeline freezes with its output held;
//   the front keeps accepting until the queue fills, then raises in_stall.
module marching_cubes_cell_triangulator import mcct_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic signed [SMP_W-1:0] cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [CELL_W-1:0]       cell_x,
	input  logic [CELL_W-1:0]       cell_y,
	input  logic [CELL_W-1:0]       cell_z,
	input  logic signed [SMP_W-1:0] corner_value_0,
	input  logic signed [SMP_W-1:0] corner_value_1,
	input  logic signed [SMP_W-1:0] corner_value_2,
	input  logic signed [SMP_W-1:0] corner_value_3,
	input  logic signed [SMP_W-1:0] corner_value_4,
	input  logic signed [SMP_W-1:0] corner_value_5,
	input  logic signed [SMP_W-1:0] corner_value_6,
	input  logic signed [SMP_W-1:0] corner_value_7,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [POS_W-1:0]        first_x,
	output logic [POS_W-1:0]        first_y,
	output logic [POS_W-1:0]        first_z,
	output logic [POS_W-1:0]        second_x,
	output logic [POS_W-1:0]        second_y,
	output logic [POS_W-1:0]        second_z,
	output logic [POS_W-1:0]        third_x,
	output logic [POS_W-1:0]        third_y,
	output logic [POS_W-1:0]        third_z,
	output logic                    last_triangle
);

	logic [SMP_W-1:0]           iso_level_q;
	logic [7:0][SMP_W-1:0]      val;
	logic                       q_full;
	logic                       q_push;
	cell_t                      q_wdata;
	logic                       q_pop;
	logic                       q_valid;
	cell_t                      q_head;
	logic [2:0][2:0][POS_W-1:0] vtx;

	// threshold register; the user must write it only while the block is idle, the block does not enforce this
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iso_level_q <= '0;
		end else if (cfg_we) begin
			iso_level_q <= cfg_wdata;
		end
	end

	assign val = {corner_value_7, corner_value_6, corner_value_5, corner_value_4,
		corner_value_3, corner_value_2, corner_value_1, corner_value_0};

	mcct_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cell_x    (cell_x),
		.cell_y    (cell_y),
		.cell_z    (cell_z),
		.val       (val),
		.iso_level (iso_level_q),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_data    (q_wdata)
	);

	mcct_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.wdata      (q_wdata),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head       (q_head)
	);

	mcct_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.iso_level     (iso_level_q),
		.head_valid    (q_valid),
		.head          (q_head),
		.head_pop      (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.vtx           (vtx),
		.last_triangle (last_triangle)
	);

	// vertex order: first, second, third; axis order x, y, z
	assign first_x  = vtx[0][0];
	assign first_y  = vtx[0][1];
	assign first_z  = vtx[0][2];
	assign second_x = vtx[1][0];
	assign second_y = vtx[1][1];
	assign second_z = vtx[1][2];
	assign third_x  = vtx[2][0];
	assign third_y  = vtx[2][1];
	assign third_z  = vtx[2][2];

endmodule
